@@ hw/rtl/dotp_pkg.sv @@
// Shared types and constants for the DHCP option TLV parser.
// No dependencies; imported by dotp_walker and dhcp_option_tlv_parser.
`timescale 1ns / 1ps

package dotp_pkg;

   localparam int OPTIONS_BYTES_DEFAULT = 312;

   localparam int BYTE_W  = 8;
   localparam int TIME_W  = 32;

   localparam logic [BYTE_W-1:0] OPT_PAD       = 8'd0;
   localparam logic [BYTE_W-1:0] OPT_END       = 8'd255;
   localparam logic [BYTE_W-1:0] OPT_LEASE     = 8'd51;
   localparam logic [BYTE_W-1:0] OPT_RENEWAL   = 8'd58;
   localparam logic [BYTE_W-1:0] OPT_REBINDING = 8'd59;

   // Index of the final magic cookie byte within the field
   localparam int COOKIE_LAST = 3;

   typedef enum logic [2:0] {
      PH_COOKIE = 3'd0,
      PH_TYPE   = 3'd1,
      PH_LENGTH = 3'd2,
      PH_DATA0  = 3'd3,
      PH_DATA1  = 3'd4,
      PH_DATA2  = 3'd5,
      PH_DATA3  = 3'd6,
      PH_DONE   = 3'd7
   } phase_type;

   typedef struct packed {
      logic [TIME_W-1:0] lease_seconds;
      logic [TIME_W-1:0] renewal_seconds;
      logic [TIME_W-1:0] rebinding_seconds;
      logic              ended_by_marker;
      logic              cut_short;
   } result_type;

endpackage

@@ hw/rtl/dotp_walker.sv @@
// Option walk state and stored lease/renewal/rebinding times.
// Depends on dotp_pkg; one byte is folded into the state per step.
`timescale 1ns / 1ps

module dotp_walker #(
   parameter int OPTIONS_BYTES = dotp_pkg::OPTIONS_BYTES_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [dotp_pkg::BYTE_W-1:0] opt_byte,
   input  logic                        last_byte,
   output dotp_pkg::result_type        result_in
);
   import dotp_pkg::*;

   localparam int POS_W = $clog2(OPTIONS_BYTES + 1);
   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(OPTIONS_BYTES);
   localparam logic [POS_W-1:0] POS_COOKIE_LAST = POS_W'(COOKIE_LAST);

   logic [POS_W-1:0]  pos_ff, pos_in;
   phase_type         phase_ff, phase_in;
   logic [BYTE_W-1:0] type_ff, type_in;
   logic [BYTE_W-1:0] left_ff, left_in;
   logic [TIME_W-1:0] acc_ff, acc_in;
   logic [TIME_W-1:0] lease_ff, lease_in;
   logic [TIME_W-1:0] renewal_ff, renewal_in;
   logic [TIME_W-1:0] rebind_ff, rebind_in;

   phase_type         phase_walk;
   logic              in_field;

   always_comb begin
      phase_walk = phase_ff;
      type_in    = type_ff;
      left_in    = left_ff;
      acc_in     = acc_ff;
      lease_in   = lease_ff;
      renewal_in = renewal_ff;
      rebind_in  = rebind_ff;
      pos_in     = pos_ff;
      in_field   = pos_ff < POS_LIMIT;

      if (step && in_field) begin
         pos_in = pos_ff + POS_W'(1);
         unique case (phase_ff)
            PH_COOKIE: begin
               if (pos_ff >= POS_COOKIE_LAST) phase_walk = PH_TYPE;
            end
            PH_TYPE: begin
               if (opt_byte == OPT_PAD || opt_byte == OPT_END) begin
                  phase_walk = PH_DONE;
               end else begin
                  type_in    = opt_byte;
                  phase_walk = PH_LENGTH;
               end
            end
            PH_LENGTH: begin
               left_in    = opt_byte;
               acc_in     = '0;
               phase_walk = (opt_byte == '0) ? PH_TYPE : PH_DATA0;
            end
            PH_DONE: begin
            end
            default: begin
               // data bytes: shift in, store on the fourth, skip the rest
               acc_in = {acc_ff[TIME_W-BYTE_W-1:0], opt_byte};
               unique case (phase_ff)
                  PH_DATA0: phase_walk = PH_DATA1;
                  PH_DATA1: phase_walk = PH_DATA2;
                  PH_DATA2: phase_walk = PH_DATA3;
                  default: begin
                     if (type_ff == OPT_LEASE)          lease_in   = acc_in;
                     else if (type_ff == OPT_RENEWAL)   renewal_in = acc_in;
                     else if (type_ff == OPT_REBINDING) rebind_in  = acc_in;
                     type_in    = '0;
                     phase_walk = PH_DATA0;
                  end
               endcase
               left_in = left_ff - BYTE_W'(1);
               if (left_in == '0) phase_walk = PH_TYPE;
            end
         endcase
      end

      result_in.lease_seconds     = lease_in;
      result_in.renewal_seconds   = renewal_in;
      result_in.rebinding_seconds = rebind_in;
      result_in.ended_by_marker   = (phase_walk == PH_DONE);
      result_in.cut_short         = (phase_walk == PH_LENGTH) || (phase_walk == PH_DATA0) ||
                                    (phase_walk == PH_DATA1) || (phase_walk == PH_DATA2) ||
                                    (phase_walk == PH_DATA3);

      phase_in = phase_walk;
      // packet end: drop the walk, keep the stored times
      if (step && last_byte) begin
         pos_in   = '0;
         phase_in = PH_COOKIE;
         type_in  = '0;
         left_in  = '0;
         acc_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         phase_ff   <= PH_COOKIE;
         type_ff    <= '0;
         left_ff    <= '0;
         acc_ff     <= '0;
         lease_ff   <= '0;
         renewal_ff <= '0;
         rebind_ff  <= '0;
      end else begin
         pos_ff     <= pos_in;
         phase_ff   <= phase_in;
         type_ff    <= type_in;
         left_ff    <= left_in;
         acc_ff     <= acc_in;
         lease_ff   <= lease_in;
         renewal_ff <= renewal_in;
         rebind_ff  <= rebind_in;
      end
   end

   a_data_has_bytes: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA0 || phase_ff == PH_DATA1 || phase_ff == PH_DATA2 ||
       phase_ff == PH_DATA3) |-> left_ff != '0)
      else $error("data phase with no bytes left");

   a_packet_end_clears: assert property (@(posedge clock) disable iff (reset)
      (step && last_byte) |=> (phase_ff == PH_COOKIE && pos_ff == '0))
      else $error("walk not cleared after last byte");

   a_pos_bounded: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_LIMIT)
      else $error("byte position beyond field limit");

   a_idle_holds_times: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(lease_ff) && $stable(renewal_ff) && $stable(rebind_ff))
      else $error("stored time changed without a byte");

endmodule

@@ hw/rtl/dhcp_option_tlv_parser.sv @@
// A transfer on req_ passes the input register, then the result register, before its result shows on rsp_.
// Throughput: one options byte per cycle while req_stall is low; the walker folds each byte in a single short step.
// A last byte waits in the input register only while a finished result is still stalled.
// Reset (synchronous, active high) clears the walk and sets all three stored times to zero.
// Depends on dotp_pkg and dotp_walker.
`timescale 1ns / 1ps

module dhcp_option_tlv_parser #(
   parameter int OPTIONS_BYTES = dotp_pkg::OPTIONS_BYTES_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   // byte stream in
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [dotp_pkg::BYTE_W-1:0] req_opt_byte,
   input  logic                        req_last_byte,
   // one result per packet
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [dotp_pkg::TIME_W-1:0] rsp_lease_seconds,
   output logic [dotp_pkg::TIME_W-1:0] rsp_renewal_seconds,
   output logic [dotp_pkg::TIME_W-1:0] rsp_rebinding_seconds,
   output logic                        rsp_ended_by_marker,
   output logic                        rsp_cut_short
);
   import dotp_pkg::*;

   // input register
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_last_ff;

   // result register
   logic              out_valid_ff, out_valid_in;
   result_type        out_ff;
   result_type        result_in;

   logic              out_free;
   logic              advance;
   logic              req_take;

   // The result slot is free if empty or being drained this cycle.
   // Only a last byte needs that slot, so other bytes never wait.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (!in_last_ff || out_free);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   dotp_walker #(
      .OPTIONS_BYTES (OPTIONS_BYTES)
   ) u_walker (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .opt_byte  (in_byte_ff),
      .last_byte (in_last_ff),
      .result_in (result_in)
   );

   always_comb begin
      // refill the input register whenever it moves on or is empty
      in_valid_in = req_stall ? in_valid_ff : req_valid;

      // load a result on a last byte, drop it once taken, else hold
      if (advance && in_last_ff) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers: no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_opt_byte;
         in_last_ff <= req_last_byte;
      end
      if (advance && in_last_ff) begin
         out_ff <= result_in;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_lease_seconds     = out_ff.lease_seconds;
   assign rsp_renewal_seconds   = out_ff.renewal_seconds;
   assign rsp_rebinding_seconds = out_ff.rebinding_seconds;
   assign rsp_ended_by_marker   = out_ff.ended_by_marker;
   assign rsp_cut_short         = out_ff.cut_short;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |-> !(advance && in_last_ff))
      else $error("stalled result overwritten");

   a_result_only_on_last: assert property (@(posedge clock) disable iff (reset)
      (!out_valid_ff && out_valid_in) |-> (advance && in_last_ff))
      else $error("result raised without a last byte");

   a_plain_byte_flows: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !in_last_ff) |-> !req_stall)
      else $error("non-last byte held in input register");

endmodule
